// File: rtl/core/xorshift_bounded_random_macros.svh
// Assertion helpers for the bounded random generator.
`ifndef XORSHIFT_BOUNDED_RANDOM_MACROS_SVH
`define XORSHIFT_BOUNDED_RANDOM_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define XBR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define XBR_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/core/xbr_pkg.sv
package xbr_pkg;

   typedef enum logic [1:0] {
      FUNC_RAW     = 2'd0,
      FUNC_BYTE    = 2'd1,
      FUNC_WORD_U  = 2'd2,
      FUNC_WORD_S  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_STEP,
      ST_MOD,
      ST_CHECK,
      ST_MUL,
      ST_ADD,
      ST_FINISH
   } state_type;

   localparam logic [31:0] GEN_RESET     = 32'h1234_5678;
   localparam logic [31:0] GEN_ZERO_FILL = 32'hdead_beef;
   localparam logic [31:0] SIGN_FLIP     = 32'h8000_0000;
   localparam int unsigned SHIFT_A       = 13;
   localparam int unsigned SHIFT_B       = 17;
   localparam int unsigned SHIFT_C       = 5;
   localparam logic [9:0]  BYTE_SPAN     = 10'd256;
   localparam logic [2:0]  MOD_LAST_BIT  = 3'd7;

endpackage

// File: rtl/core/xorshift_bounded_random.sv
// A request takes one transfer on the req_ channel and returns exactly one
// transfer on the rsp_ channel. The block works on one request at a time and
// holds req_stall high until it is idle again; a finished result waits in the
// output register, so the next request can be taken while it is pending. A raw
// word steps the generator once; an equal-bounds request returns that bound
// without a draw; a 32-bit range request draws, then the 32x32 multiply has its
// own state before the low bound is added; an 8-bit range request draws a byte,
// the 9-bit compare-and-subtract unit forms the remainder one bit per cycle,
// and a check for rejection follows; a rejected byte repeats the draw.
`include "xorshift_bounded_random_macros.svh"

module xorshift_bounded_random
   import xbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_low_bound,
   input  logic [31:0] req_high_bound,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value
);

   state_type   state_ff, state_in;
   func_type    func_ff, func_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] range_ff, range_in;
   logic [31:0] rnd_ff, rnd_in;
   logic [63:0] prod_ff, prod_in;
   logic [7:0]  rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] result_ff, result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   logic        req_accept;
   logic        rsp_load;
   logic [31:0] gen_step;
   logic [31:0] gen_next;
   logic [31:0] bound_a;
   logic [31:0] bound_b;
   logic [31:0] key_a;
   logic [31:0] key_b;
   logic        bounds_equal;
   logic        bounds_swap;
   logic [31:0] bound_lo;
   logic [31:0] bound_hi;
   logic [8:0]  mod_trial;
   logic        mod_fits;
   logic [9:0]  block_end;
   logic        byte_reject;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      gen_step = gen_ff ^ (gen_ff << SHIFT_A);
      gen_step = gen_step ^ (gen_step >> SHIFT_B);
      gen_step = gen_step ^ (gen_step << SHIFT_C);
      gen_next = (gen_step != 32'd0) ? gen_step : GEN_ZERO_FILL;
   end

   // Bound ordering: byte mode looks at the low bytes only, signed mode
   // compares with the sign bit flipped.
   always_comb begin
      bound_a = (func_ff == FUNC_BYTE) ? {24'd0, lo_ff[7:0]} : lo_ff;
      bound_b = (func_ff == FUNC_BYTE) ? {24'd0, hi_ff[7:0]} : hi_ff;
      key_a   = (func_ff == FUNC_WORD_S) ? (bound_a ^ SIGN_FLIP) : bound_a;
      key_b   = (func_ff == FUNC_WORD_S) ? (bound_b ^ SIGN_FLIP) : bound_b;
      bounds_equal = (bound_a == bound_b);
      bounds_swap  = (key_a > key_b);
      bound_lo = bounds_swap ? bound_b : bound_a;
      bound_hi = bounds_swap ? bound_a : bound_b;
   end

   // Remainder unit: one restoring step per cycle.
   assign mod_trial = {rem_ff, rnd_ff[3'(MOD_LAST_BIT - cnt_ff)]};
   assign mod_fits  = (mod_trial >= {1'b0, range_ff[7:0]});

   // A byte is rejected when its block of width r would run past 256.
   assign block_end   = {2'd0, rnd_ff[7:0]} - {2'd0, rem_ff} + {2'd0, range_ff[7:0]};
   assign byte_reject = (block_end > BYTE_SPAN);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (func_ff != FUNC_RAW && bounds_equal) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            unique case (func_ff)
               FUNC_RAW:  state_in = ST_FINISH;
               FUNC_BYTE: state_in = ST_MOD;
               default:   state_in = ST_MUL;
            endcase
         end
         ST_MOD: begin
            if (cnt_ff == MOD_LAST_BIT) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = byte_reject ? ST_STEP : ST_FINISH;
         end
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      func_in      = func_ff;
      gen_in       = gen_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      range_in     = range_ff;
      rnd_in       = rnd_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in = func_type'(req_func);
               lo_in   = req_low_bound;
               hi_in   = req_high_bound;
            end
         end
         ST_SETUP: begin
            lo_in     = bound_lo;
            hi_in     = bound_hi;
            range_in  = bound_hi - bound_lo;
            result_in = bound_a;
         end
         ST_STEP: begin
            gen_in    = gen_next;
            rnd_in    = gen_next;
            result_in = gen_next;
            rem_in    = 8'd0;
            cnt_in    = 3'd0;
         end
         ST_MOD: begin
            rem_in = mod_fits ? 8'(mod_trial - {1'b0, range_ff[7:0]}) : mod_trial[7:0];
            cnt_in = cnt_ff + 3'd1;
         end
         ST_CHECK: begin
            result_in = {24'd0, lo_ff[7:0] + rem_ff};
         end
         ST_MUL: begin
            prod_in = {32'd0, rnd_ff} * {32'd0, range_ff};
         end
         ST_ADD: begin
            result_in = lo_ff + prod_ff[63:32];
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= GEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      range_ff     <= range_in;
      rnd_ff       <= rnd_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   `XBR_NEVER(a_gen_nonzero, gen_ff == 32'd0, "Generator reached zero.")
   `XBR_ASSERT(a_accept_setup, req_accept |=> state_ff == ST_SETUP,
      "Accepted request did not enter setup.")
   `XBR_ASSERT(a_rem_bounded, state_ff == ST_MOD |-> rem_ff < range_ff[7:0],
      "Remainder is not below the byte range.")
   `XBR_ASSERT(a_byte_result, rsp_load && func_ff == FUNC_BYTE |=> rsp_value[31:8] == 24'd0,
      "Byte mode result has upper bits set.")

endmodule
